[rtl/core/ahcs_pkg.sv]
// Shared types, codes and result builder for the ATA PIO host command sequencer.
package ahcs_pkg;

  // Request from the host side: command or returned bus word
  typedef struct packed {
    logic [1:0]  func;
    logic [27:0] lba;
    logic [7:0]  num_sectors;
    logic [15:0] bus_word;
  } req_t;

  // One bus step, data item, completion or reset-line change
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  reg_addr;
    logic [15:0] write_word;
    logic [7:0]  data_low_byte;
    logic [7:0]  data_high_byte;
    logic [31:0] sector_total;
    logic        error_flag;
    logic [6:0]  error_bits;
    logic        reset_drive;
    logic        last;
  } res_t;

  // Request function codes
  localparam logic [1:0] FUNC_READ     = 2'd0;
  localparam logic [1:0] FUNC_IDENTIFY = 2'd1;
  localparam logic [1:0] FUNC_WORD     = 2'd2;
  localparam logic [1:0] FUNC_RESET    = 2'd3;

  // Result kind codes
  localparam logic [2:0] KIND_REG_READ  = 3'd0;
  localparam logic [2:0] KIND_REG_WRITE = 3'd1;
  localparam logic [2:0] KIND_DATA      = 3'd2;
  localparam logic [2:0] KIND_DONE      = 3'd3;
  localparam logic [2:0] KIND_RESET     = 3'd4;

  // Register addresses: CS0 CS1 A2 A1 A0
  localparam logic [4:0] ADDR_DATA     = 5'b01000;
  localparam logic [4:0] ADDR_ERROR    = 5'b01001;
  localparam logic [4:0] ADDR_COUNT    = 5'b01010;
  localparam logic [4:0] ADDR_SECTOR   = 5'b01011;
  localparam logic [4:0] ADDR_CYL_LOW  = 5'b01100;
  localparam logic [4:0] ADDR_CYL_HIGH = 5'b01101;
  localparam logic [4:0] ADDR_HEAD     = 5'b01110;
  localparam logic [4:0] ADDR_STATUS   = 5'b01111;

  // Register values
  localparam logic [7:0] HEAD_LBA_MASTER = 8'hE0;
  localparam logic [7:0] CMD_READ        = 8'h20;
  localparam logic [7:0] CMD_IDENTIFY    = 8'hEC;

  // Status bit positions
  localparam int ST_ERR_BIT = 0;
  localparam int ST_DRQ_BIT = 3;
  localparam int ST_RDY_BIT = 6;
  localparam int ST_BSY_BIT = 7;

  // Sector geometry and identify words holding the sector total
  localparam int WORDS_PER_SECTOR = 256;
  localparam int SECTOR_BITS      = $clog2(WORDS_PER_SECTOR);
  localparam logic [8:0] ID_WORDS    = 9'd256;
  localparam logic [8:0] ID_TOTAL_LO = 9'd60;
  localparam logic [8:0] ID_TOTAL_HI = 9'd61;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_POLL,
    PH_ID_READY,
    PH_ID_DRQ,
    PH_ID_DATA,
    PH_RD_READY,
    PH_RD_DRQ,
    PH_RD_DATA,
    PH_ERR_READ,
    PH_HALTED
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_IDENT,
    CMD_RDSEC
  } active_t;

  // Result scripts that the back end plays out
  typedef enum logic [2:0] {
    SC_READ,     // one register read at addr
    SC_RESET,    // reset pulse, head select, status read
    SC_ERROR,    // reset assert, error completion
    SC_DONE,     // completion carrying arg as sector total
    SC_ID_CMD,   // identify command, status read
    SC_RD_CMD,   // taskfile writes, read command, status read
    SC_DATA      // data item, optional read at addr
  } script_t;

  typedef struct packed {
    script_t     script;
    logic [4:0]  addr;
    logic [31:0] arg;
    logic [7:0]  count;
    logic        last;
    logic        follow;
  } plan_t;

  // Number of results a plan produces
  function automatic logic [2:0] script_len(plan_t p);
    logic [2:0] n;
    n = 3'd1;
    unique case (p.script)
      SC_READ:   n = 3'd1;
      SC_RESET:  n = 3'd4;
      SC_ERROR:  n = 3'd2;
      SC_DONE:   n = 3'd1;
      SC_ID_CMD: n = 3'd2;
      SC_RD_CMD: n = 3'd7;
      SC_DATA:   n = p.follow ? 3'd2 : 3'd1;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  // Result for one step of a plan
  function automatic res_t build_item(plan_t p, logic [2:0] step);
    res_t r;
    r = '0;
    unique case (p.script)
      SC_READ: begin
        r.kind     = KIND_REG_READ;
        r.reg_addr = p.addr;
      end
      SC_RESET: begin
        unique case (step)
          3'd0: begin
            r.kind        = KIND_RESET;
            r.reset_drive = 1'b1;
          end
          3'd1: r.kind = KIND_RESET;
          3'd2: begin
            r.kind       = KIND_REG_WRITE;
            r.reg_addr   = ADDR_HEAD;
            r.write_word = {8'h00, HEAD_LBA_MASTER};
          end
          default: begin
            r.kind     = KIND_REG_READ;
            r.reg_addr = ADDR_STATUS;
          end
        endcase
      end
      SC_ERROR: begin
        if (step == 3'd0) begin
          r.kind        = KIND_RESET;
          r.reset_drive = 1'b1;
        end else begin
          r.kind       = KIND_DONE;
          r.error_flag = 1'b1;
          r.error_bits = p.arg[6:0];
        end
      end
      SC_DONE: begin
        r.kind         = KIND_DONE;
        r.sector_total = p.arg;
      end
      SC_ID_CMD: begin
        if (step == 3'd0) begin
          r.kind       = KIND_REG_WRITE;
          r.reg_addr   = ADDR_STATUS;
          r.write_word = {8'h00, CMD_IDENTIFY};
        end else begin
          r.kind     = KIND_REG_READ;
          r.reg_addr = ADDR_STATUS;
        end
      end
      SC_RD_CMD: begin
        r.kind = KIND_REG_WRITE;
        unique case (step)
          3'd0: begin
            r.reg_addr   = ADDR_HEAD;
            r.write_word = {8'h00, HEAD_LBA_MASTER | {4'h0, p.arg[27:24]}};
          end
          3'd1: begin
            r.reg_addr   = ADDR_CYL_HIGH;
            r.write_word = {8'h00, p.arg[23:16]};
          end
          3'd2: begin
            r.reg_addr   = ADDR_CYL_LOW;
            r.write_word = {8'h00, p.arg[15:8]};
          end
          3'd3: begin
            r.reg_addr   = ADDR_SECTOR;
            r.write_word = {8'h00, p.arg[7:0]};
          end
          3'd4: begin
            r.reg_addr   = ADDR_COUNT;
            r.write_word = {8'h00, p.count};
          end
          3'd5: begin
            r.reg_addr   = ADDR_STATUS;
            r.write_word = {8'h00, CMD_READ};
          end
          default: begin
            r.kind     = KIND_REG_READ;
            r.reg_addr = ADDR_STATUS;
          end
        endcase
      end
      SC_DATA: begin
        if (step == 3'd0) begin
          r.kind           = KIND_DATA;
          r.data_low_byte  = p.arg[7:0];
          r.data_high_byte = p.arg[15:8];
          r.last           = p.last;
        end else begin
          r.kind     = KIND_REG_READ;
          r.reg_addr = p.addr;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ahcs_front.sv]
// Front end: accepts requests, runs the command state machine, queues result plans.
module ahcs_front
  import ahcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  req_t  req,
  output logic  push,
  output plan_t plan
);

  phase_t      phase, phase_next;
  active_t     active, active_next;
  logic [27:0] pending_lba, pending_lba_next;
  logic [7:0]  pending_count, pending_count_next;
  logic [15:0] words_remaining, words_remaining_next;
  logic [8:0]  identify_index, identify_index_next;
  logic [15:0] cap_low, cap_low_next;
  logic [15:0] cap_high, cap_high_next;

  logic [15:0] w;
  logic        poll_phase;
  logic        drq_phase;
  logic        status_ok;
  logic [8:0]  id_inc;
  logic [15:0] wr_dec;

  // Decode the returned word against the current poll
  assign w          = req.bus_word;
  assign drq_phase  = (phase == PH_ID_DRQ) || (phase == PH_RD_DRQ);
  assign poll_phase = drq_phase || (phase == PH_RST_POLL) || (phase == PH_ID_READY)
                      || (phase == PH_RD_READY);
  assign status_ok  = drq_phase ? w[ST_DRQ_BIT] : (w[ST_RDY_BIT] && !w[ST_BSY_BIT]);
  assign id_inc     = identify_index + 9'd1;
  assign wr_dec     = (words_remaining == 16'd0) ? 16'd0 : words_remaining - 16'd1;

  // Next state
  always_comb begin
    phase_next           = phase;
    active_next          = active;
    pending_lba_next     = pending_lba;
    pending_count_next   = pending_count;
    words_remaining_next = words_remaining;
    identify_index_next  = identify_index;
    cap_low_next         = cap_low;
    cap_high_next        = cap_high;
    if (accept) begin
      priority if (phase == PH_HALTED) begin
        phase_next = PH_HALTED;
      end else if (req.func == FUNC_WORD) begin
        priority if (phase == PH_ERR_READ) begin
          phase_next = PH_HALTED;
        end else if (poll_phase) begin
          priority if (w[ST_ERR_BIT]) begin
            phase_next = PH_ERR_READ;
          end else if (status_ok) begin
            priority case (phase)
              PH_RST_POLL: begin
                if (active == CMD_IDENT) begin
                  phase_next = PH_ID_READY;
                end else begin
                  phase_next  = PH_IDLE;
                  active_next = CMD_NONE;
                end
              end
              PH_ID_READY: phase_next = PH_ID_DRQ;
              PH_RD_READY: phase_next = PH_RD_DRQ;
              PH_ID_DRQ: begin
                phase_next          = PH_ID_DATA;
                identify_index_next = 9'd0;
              end
              default: phase_next = PH_RD_DATA;
            endcase
          end else begin
            phase_next = phase;
          end
        end else if (phase == PH_ID_DATA) begin
          if (identify_index == ID_TOTAL_LO) cap_low_next = w;
          if (identify_index == ID_TOTAL_HI) cap_high_next = w;
          identify_index_next = id_inc;
          if (id_inc >= ID_WORDS) begin
            phase_next  = PH_IDLE;
            active_next = CMD_NONE;
          end
        end else if (phase == PH_RD_DATA) begin
          words_remaining_next = wr_dec;
          if (wr_dec == 16'd0) begin
            phase_next  = PH_IDLE;
            active_next = CMD_NONE;
          end else if (wr_dec[SECTOR_BITS-1:0] == '0) begin
            phase_next = PH_RD_DRQ;
          end
        end else begin
          // Drop a stray word in idle
          phase_next = phase;
        end
      end else if (phase == PH_ERR_READ) begin
        phase_next = PH_ERR_READ;
      end else if (req.func == FUNC_RESET) begin
        phase_next  = PH_RST_POLL;
        active_next = CMD_NONE;
      end else if (phase != PH_IDLE) begin
        phase_next = phase;
      end else if (req.func == FUNC_IDENTIFY) begin
        phase_next  = PH_RST_POLL;
        active_next = CMD_IDENT;
      end else if (req.num_sectors != 8'd0) begin
        pending_lba_next     = req.lba;
        pending_count_next   = req.num_sectors;
        words_remaining_next = 16'(32'(req.num_sectors) * WORDS_PER_SECTOR);
        active_next          = CMD_RDSEC;
        phase_next           = PH_RD_READY;
      end else begin
        // Drop a read of zero sectors
        phase_next = phase;
      end
    end
  end

  // Result plan for the accepted request
  always_comb begin
    push = 1'b0;
    plan = '0;
    if (accept) begin
      priority if (phase == PH_HALTED) begin
        push = 1'b0;
      end else if (req.func == FUNC_WORD) begin
        priority if (phase == PH_ERR_READ) begin
          push        = 1'b1;
          plan.script = SC_ERROR;
          plan.arg    = {16'h0000, w};
        end else if (poll_phase) begin
          push        = 1'b1;
          plan.script = SC_READ;
          priority if (w[ST_ERR_BIT]) begin
            plan.addr = ADDR_ERROR;
          end else if (status_ok) begin
            priority case (phase)
              PH_RST_POLL: begin
                if (active == CMD_IDENT) begin
                  plan.addr = ADDR_STATUS;
                end else begin
                  plan.script = SC_DONE;
                end
              end
              PH_ID_READY: plan.script = SC_ID_CMD;
              PH_RD_READY: begin
                plan.script = SC_RD_CMD;
                plan.arg    = {4'h0, pending_lba};
                plan.count  = pending_count;
              end
              default: plan.addr = ADDR_DATA;
            endcase
          end else begin
            plan.addr = ADDR_STATUS;
          end
        end else if (phase == PH_ID_DATA) begin
          push = 1'b1;
          if (id_inc >= ID_WORDS) begin
            plan.script = SC_DONE;
            plan.arg    = {cap_high_next, cap_low_next};
          end else begin
            plan.script = SC_READ;
            plan.addr   = ADDR_DATA;
          end
        end else if (phase == PH_RD_DATA) begin
          push        = 1'b1;
          plan.script = SC_DATA;
          plan.arg    = {16'h0000, w};
          plan.last   = (words_remaining <= 16'd1);
          plan.follow = (wr_dec != 16'd0);
          plan.addr   = (wr_dec[SECTOR_BITS-1:0] == '0) ? ADDR_STATUS : ADDR_DATA;
        end else begin
          push = 1'b0;
        end
      end else if (phase == PH_ERR_READ) begin
        push = 1'b0;
      end else if (req.func == FUNC_RESET) begin
        push        = 1'b1;
        plan.script = SC_RESET;
      end else if (phase != PH_IDLE) begin
        push = 1'b0;
      end else if (req.func == FUNC_IDENTIFY) begin
        push        = 1'b1;
        plan.script = SC_RESET;
      end else if (req.num_sectors != 8'd0) begin
        push        = 1'b1;
        plan.script = SC_READ;
        plan.addr   = ADDR_STATUS;
      end else begin
        push = 1'b0;
      end
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      active          <= CMD_NONE;
      pending_lba     <= '0;
      pending_count   <= '0;
      words_remaining <= '0;
      identify_index  <= '0;
      cap_low         <= '0;
      cap_high        <= '0;
    end else begin
      phase           <= phase_next;
      active          <= active_next;
      pending_lba     <= pending_lba_next;
      pending_count   <= pending_count_next;
      words_remaining <= words_remaining_next;
      identify_index  <= identify_index_next;
      cap_low         <= cap_low_next;
      cap_high        <= cap_high_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALTED |=> phase == PH_HALTED)
    else $error("halted state left without reset");
`endif

endmodule

[rtl/core/ahcs_queue.sv]
// Plan queue between the front and back ends.
module ahcs_queue
  import ahcs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  plan_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output plan_t head_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  plan_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // Store pushed plans
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("plan queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("plan queue count out of range");
`endif

endmodule

[rtl/core/ahcs_back.sv]
// Back end: plays each queued plan out as results through an output register.
module ahcs_back
  import ahcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  plan_t head,
  output logic  pop,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  logic [2:0] step;
  logic [2:0] len;
  logic       load;
  logic       final_step;

  assign len        = script_len(head);
  assign final_step = (step == len - 3'd1);
  assign load       = head_valid && (!res_valid || res_ready);
  assign pop        = load && final_step;

  // Walk the steps of the head plan
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        step      <= final_step ? 3'd0 : step + 3'd1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) res <= build_item(head, step);
  end

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> step < len)
    else $error("plan step past end of script");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> step == 3'd0)
    else $error("plan step left over with empty queue");
`endif

endmodule

[rtl/core/ata_pio_host_command_sequencer_unit.sv]
// Top level of the ATA PIO LBA28 host command sequencer.
//
// Requests (req_valid/req_ready, payload req) carry host commands (read
// sectors, identify, device reset) and words returned by register reads.
// Results (res_valid/res_ready, payload res) come out in order: register
// reads and writes, reset-line changes, sector data bytes and completions.
// A request yields zero to seven results.
// The front end decodes a request in its accept cycle and queues a plan;
// the back end expands one plan step per cycle into the output register
// while the receiver is ready. With the back end free, the first result of
// a request passes through the plan queue and then the output register.
// One request per cycle is taken while the queue has room; a request that
// makes several results occupies the back end until all are played out.
// req_ready drops only when the QUEUE_DEPTH-entry plan queue is full, so a
// stalled receiver backs up the queue and then the request side.
// Reset (rst, synchronous) empties the queue and output register, returns
// the sequencer to idle and clears a device-error halt.
module ata_pio_host_command_sequencer_unit
  import ahcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic  accept;
  logic  push;
  plan_t plan;
  logic  full;
  logic  pop;
  logic  head_valid;
  plan_t head;

  assign req_ready = !full;
  assign accept    = req_valid && req_ready;

  ahcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .push   (push),
    .plan   (plan)
  );

  ahcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (plan),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head)
  );

  ahcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

[tb/ata_pio_host_command_sequencer_unit_tb.sv]
// Self-checking testbench for the ATA PIO host command sequencer: directed table, then random.
`timescale 1ns / 100ps

module ata_pio_host_command_sequencer_unit_tb;
  import ahcs_pkg::*;

  localparam int TOTAL_ITEMS  = 410;
  localparam int IDLE_PCT     = 17;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Stalls off for a stretch of the random part
  logic steady = 1'b0;

  // Sequencer state as the host side sees it
  phase_t      seq_phase;
  active_t     busy_cmd;
  logic [27:0] held_lba;
  logic [7:0]  held_count;
  logic [15:0] words_left;
  logic [8:0]  id_index;
  logic [15:0] total_lo;
  logic [15:0] total_hi;

  // Bus work due for the request just taken, and all bus work still owed
  res_t step_results[$];
  res_t expected_results[$];

  // Directed table: requests, typed result count (-1 means predicted), typed results
  req_t script_reqs[$];
  int   script_typed[$];
  res_t typed_results[$];
  int   head_rows;

  int failures      = 0;
  int items_sent    = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int identify_runs = 0;
  int read_runs     = 0;
  int cut_after     = -1;
  bit multi_seen    = 1'b0;

  ata_pio_host_command_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bus work items
  function automatic res_t reg_read(logic [4:0] addr);
    res_t t;
    t          = '0;
    t.kind     = KIND_REG_READ;
    t.reg_addr = addr;
    return t;
  endfunction

  function automatic res_t reg_write(logic [4:0] addr, logic [7:0] value);
    res_t t;
    t            = '0;
    t.kind       = KIND_REG_WRITE;
    t.reg_addr   = addr;
    t.write_word = {8'h00, value};
    return t;
  endfunction

  function automatic res_t reset_line(logic level);
    res_t t;
    t             = '0;
    t.kind        = KIND_RESET;
    t.reset_drive = level;
    return t;
  endfunction

  function automatic res_t completion(logic [31:0] total);
    res_t t;
    t              = '0;
    t.kind         = KIND_DONE;
    t.sector_total = total;
    return t;
  endfunction

  function automatic res_t error_completion(logic [6:0] bits);
    res_t t;
    t            = '0;
    t.kind       = KIND_DONE;
    t.error_flag = 1'b1;
    t.error_bits = bits;
    return t;
  endfunction

  // Pulse the device reset line, select the master in LBA mode, poll status
  function automatic void start_device_reset(active_t cmd);
    step_results.push_back(reset_line(1'b1));
    step_results.push_back(reset_line(1'b0));
    step_results.push_back(reg_write(ADDR_HEAD, HEAD_LBA_MASTER));
    step_results.push_back(reg_read(ADDR_STATUS));
    busy_cmd  = cmd;
    seq_phase = PH_RST_POLL;
  endfunction

  // Advance on a word returned by the pending register read
  function automatic void take_word(logic [15:0] w);
    logic ok;
    logic polling;
    logic drq_wait;
    drq_wait = (seq_phase == PH_ID_DRQ) || (seq_phase == PH_RD_DRQ);
    polling  = drq_wait || (seq_phase == PH_RST_POLL) || (seq_phase == PH_ID_READY) ||
               (seq_phase == PH_RD_READY);
    if (seq_phase == PH_ERR_READ) begin
      step_results.push_back(reset_line(1'b1));
      step_results.push_back(error_completion(w[6:0]));
      seq_phase = PH_HALTED;
    end else if (polling) begin
      if (w[ST_ERR_BIT]) begin
        seq_phase = PH_ERR_READ;
        step_results.push_back(reg_read(ADDR_ERROR));
        return;
      end
      ok = drq_wait ? w[ST_DRQ_BIT] : (w[ST_RDY_BIT] && !w[ST_BSY_BIT]);
      if (!ok) begin
        step_results.push_back(reg_read(ADDR_STATUS));
        return;
      end
      case (seq_phase)
        PH_RST_POLL: begin
          if (busy_cmd == CMD_IDENT) begin
            seq_phase = PH_ID_READY;
            step_results.push_back(reg_read(ADDR_STATUS));
          end else begin
            step_results.push_back(completion(32'd0));
            busy_cmd  = CMD_NONE;
            seq_phase = PH_IDLE;
          end
        end
        PH_ID_READY: begin
          step_results.push_back(reg_write(ADDR_STATUS, CMD_IDENTIFY));
          step_results.push_back(reg_read(ADDR_STATUS));
          seq_phase = PH_ID_DRQ;
        end
        PH_RD_READY: begin
          step_results.push_back(reg_write(ADDR_HEAD, HEAD_LBA_MASTER | {4'h0, held_lba[27:24]}));
          step_results.push_back(reg_write(ADDR_CYL_HIGH, held_lba[23:16]));
          step_results.push_back(reg_write(ADDR_CYL_LOW, held_lba[15:8]));
          step_results.push_back(reg_write(ADDR_SECTOR, held_lba[7:0]));
          step_results.push_back(reg_write(ADDR_COUNT, held_count));
          step_results.push_back(reg_write(ADDR_STATUS, CMD_READ));
          step_results.push_back(reg_read(ADDR_STATUS));
          seq_phase = PH_RD_DRQ;
        end
        PH_ID_DRQ: begin
          id_index  = '0;
          seq_phase = PH_ID_DATA;
          step_results.push_back(reg_read(ADDR_DATA));
        end
        default: begin
          seq_phase = PH_RD_DATA;
          step_results.push_back(reg_read(ADDR_DATA));
        end
      endcase
    end else if (seq_phase == PH_ID_DATA) begin
      // Keep the capacity words, swallow the rest of the identify block
      if (id_index == ID_TOTAL_LO) total_lo = w;
      if (id_index == ID_TOTAL_HI) total_hi = w;
      id_index = id_index + 9'd1;
      if (id_index >= ID_WORDS) begin
        step_results.push_back(completion({total_hi, total_lo}));
        busy_cmd  = CMD_NONE;
        seq_phase = PH_IDLE;
      end else begin
        step_results.push_back(reg_read(ADDR_DATA));
      end
    end else if (seq_phase == PH_RD_DATA) begin
      step_results.push_back('{kind: KIND_DATA, reg_addr: 5'd0, write_word: 16'd0,
                               data_low_byte: w[7:0], data_high_byte: w[15:8],
                               sector_total: 32'd0, error_flag: 1'b0, error_bits: 7'd0,
                               reset_drive: 1'b0, last: (words_left <= 16'd1)});
      if (words_left != 16'd0) words_left = words_left - 16'd1;
      if (words_left == 16'd0) begin
        busy_cmd  = CMD_NONE;
        seq_phase = PH_IDLE;
      end else if ((words_left % WORDS_PER_SECTOR) == 0) begin
        seq_phase = PH_RD_DRQ;
        step_results.push_back(reg_read(ADDR_STATUS));
      end else begin
        step_results.push_back(reg_read(ADDR_DATA));
      end
    end
  endfunction

  // Work out the bus work caused by one accepted request
  function automatic void apply_request(req_t r);
    step_results.delete();
    if (seq_phase == PH_HALTED) return;
    if (r.func == FUNC_WORD) begin
      take_word(r.bus_word);
      return;
    end
    if (seq_phase == PH_ERR_READ) return;
    if (r.func == FUNC_RESET) begin
      start_device_reset(CMD_NONE);
      return;
    end
    if (seq_phase != PH_IDLE) return;
    if (r.func == FUNC_IDENTIFY) begin
      start_device_reset(CMD_IDENT);
      return;
    end
    if (r.num_sectors == 8'd0) return;
    held_lba   = r.lba;
    held_count = r.num_sectors;
    words_left = 16'(32'(r.num_sectors) * WORDS_PER_SECTOR);
    busy_cmd   = CMD_RDSEC;
    seq_phase  = PH_RD_READY;
    step_results.push_back(reg_read(ADDR_STATUS));
  endfunction

  // Pick the next request from what the sequencer is waiting for
  function automatic req_t next_request();
    req_t r;
    int   roll;
    logic ok;
    r.func        = FUNC_WORD;
    r.lba         = 28'($urandom);
    r.num_sectors = 8'($urandom);
    r.bus_word    = 16'($urandom);
    roll          = $urandom_range(0, 99);
    ok            = (roll >= 30);
    case (seq_phase)
      PH_IDLE: begin
        if (identify_runs == 0 || roll < 8) begin
          r.func = FUNC_IDENTIFY;
        end else if (roll < 14) begin
          r.func = FUNC_RESET;
        end else if (roll < 20) begin
          r.func = FUNC_WORD;
        end else begin
          r.func = FUNC_READ;
          if (roll < 25) begin
            r.num_sectors = 8'd0;
          end else if (!multi_seen) begin
            r.num_sectors = 8'd2;
            cut_after     = -1;
          end else if (roll < 45) begin
            r.num_sectors = 8'($urandom_range(3, 255));
            cut_after     = $urandom_range(0, 40);
          end else begin
            r.num_sectors = 8'd1;
            cut_after     = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 60) : -1;
          end
        end
      end
      PH_ID_DATA, PH_RD_DATA: begin
        if (seq_phase == PH_RD_DATA && cut_after == 0) begin
          r.func    = FUNC_RESET;
          cut_after = -1;
        end else if (seq_phase == PH_ID_DATA && identify_runs != 0 && roll < 2) begin
          r.func = FUNC_RESET;
        end else if (roll < 5) begin
          r.func = (roll % 2) ? FUNC_READ : FUNC_IDENTIFY;
        end else if (seq_phase == PH_RD_DATA && cut_after > 0) begin
          cut_after = cut_after - 1;
        end
      end
      default: begin
        // Status polls: mostly answers, some aborts and requests that come too early
        if (roll < 4) begin
          r.func = FUNC_RESET;
        end else if (roll < 9) begin
          r.func = (roll % 2) ? FUNC_READ : FUNC_IDENTIFY;
        end else begin
          r.bus_word[ST_ERR_BIT] = 1'b0;
          if (seq_phase == PH_ID_DRQ || seq_phase == PH_RD_DRQ) begin
            r.bus_word[ST_DRQ_BIT] = ok;
          end else if (ok) begin
            r.bus_word[ST_RDY_BIT] = 1'b1;
            r.bus_word[ST_BSY_BIT] = 1'b0;
          end else if ($urandom_range(0, 1)) begin
            r.bus_word[ST_BSY_BIT] = 1'b1;
          end else begin
            r.bus_word[ST_RDY_BIT] = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Present one request, hold it until taken, then record the bus work it owes
  task automatic issue(input req_t r, input int typed_n);
    phase_t prior;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    prior = seq_phase;
    apply_request(r);
    items_sent++;
    if (step_results.size() != 0) items_taken++;
    if (typed_n < 0) begin
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end else begin
      repeat (typed_n) expected_results.push_back(typed_results.pop_front());
    end
    if (prior == PH_ID_DATA && seq_phase == PH_IDLE) identify_runs++;
    if (prior == PH_RD_DATA && seq_phase == PH_IDLE) begin
      read_runs++;
      if (held_count >= 8'd2) multi_seen = 1'b1;
    end
  endtask

  task automatic play_rows(input int first, input int stop);
    for (int i = first; i < stop; i++) issue(script_reqs[i], script_typed[i]);
  endtask

  function automatic void stim(logic [1:0] func, logic [27:0] lba, logic [7:0] cnt,
                               logic [15:0] word, int typed_n);
    req_t r;
    r.func        = func;
    r.lba         = lba;
    r.num_sectors = cnt;
    r.bus_word    = word;
    script_reqs.push_back(r);
    script_typed.push_back(typed_n);
  endfunction

  function automatic void want(res_t t);
    typed_results.push_back(t);
  endfunction

  function automatic void want_reset_seq();
    want(reset_line(1'b1));
    want(reset_line(1'b0));
    want(reg_write(ADDR_HEAD, HEAD_LBA_MASTER));
    want(reg_read(ADDR_STATUS));
  endfunction

  // Directed rows: odd inputs in idle, reset, read with extreme address, early requests,
  // aborts by reset, largest sector count, identify start
  initial begin
    stim(FUNC_WORD, 28'h0, 8'd0, 16'hFFFF, 0);
    stim(FUNC_READ, 28'h1234567, 8'd0, 16'h0000, 0);
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, 4);
    want_reset_seq();
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h00C0, 1);
    want(reg_read(ADDR_STATUS));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, 1);
    want(completion(32'd0));
    stim(FUNC_READ, 28'hFFFFFFF, 8'd1, 16'h0000, 1);
    want(reg_read(ADDR_STATUS));
    stim(FUNC_IDENTIFY, 28'h0, 8'd0, 16'h0000, 0);
    stim(FUNC_READ, 28'h0000001, 8'd7, 16'h0000, 0);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0050, 7);
    want(reg_write(ADDR_HEAD, 8'hEF));
    want(reg_write(ADDR_CYL_HIGH, 8'hFF));
    want(reg_write(ADDR_CYL_LOW, 8'hFF));
    want(reg_write(ADDR_SECTOR, 8'hFF));
    want(reg_write(ADDR_COUNT, 8'h01));
    want(reg_write(ADDR_STATUS, CMD_READ));
    want(reg_read(ADDR_STATUS));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h00F6, 1);
    want(reg_read(ADDR_STATUS));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0008, 1);
    want(reg_read(ADDR_DATA));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'hFFFF, -1);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0000, -1);
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, 4);
    want_reset_seq();
    stim(FUNC_WORD, 28'h0, 8'd0, 16'hFF7E, 1);
    want(completion(32'd0));
    stim(FUNC_READ, 28'h0, 8'd255, 16'hFFFF, 1);
    want(reg_read(ADDR_STATUS));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, -1);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0008, -1);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'hA55A, -1);
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, -1);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, -1);
    stim(FUNC_IDENTIFY, 28'h0, 8'd0, 16'h0000, 4);
    want_reset_seq();
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, 1);
    want(reg_read(ADDR_STATUS));
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, 2);
    want(reg_write(ADDR_STATUS, CMD_IDENTIFY));
    want(reg_read(ADDR_STATUS));
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, -1);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, -1);
    head_rows = script_reqs.size();

    // Closing rows: device error, requests while the error register is pending, halt
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, 4);
    want_reset_seq();
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h00C1, 1);
    want(reg_read(ADDR_ERROR));
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, 0);
    stim(FUNC_READ, 28'h0ABCDEF, 8'd1, 16'h0000, 0);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'hFFFF, 2);
    want(reset_line(1'b1));
    want(error_completion(7'h7F));
    stim(FUNC_RESET, 28'h0, 8'd0, 16'h0000, 0);
    stim(FUNC_IDENTIFY, 28'h0, 8'd0, 16'h0000, 0);
    stim(FUNC_WORD, 28'h0, 8'd0, 16'h0040, 0);
  end

  // Receiver side: random stalls except during the steady stretch
  always @(posedge clk) begin
    res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      failures++;
    end
  endtask

  // Compare each taken result with the oldest one owed
  task automatic check_result(input res_t got);
    res_t owed;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result with nothing owed: kind %0d addr %0h", got.kind, got.reg_addr);
      failures++;
      return;
    end
    owed = expected_results.pop_front();
    check_field("kind", 32'(owed.kind), 32'(got.kind));
    check_field("reg_addr", 32'(owed.reg_addr), 32'(got.reg_addr));
    check_field("write_word", 32'(owed.write_word), 32'(got.write_word));
    check_field("data_low_byte", 32'(owed.data_low_byte), 32'(got.data_low_byte));
    check_field("data_high_byte", 32'(owed.data_high_byte), 32'(got.data_high_byte));
    check_field("sector_total", owed.sector_total, got.sector_total);
    check_field("error_flag", 32'(owed.error_flag), 32'(got.error_flag));
    check_field("error_bits", 32'(owed.error_bits), 32'(got.error_bits));
    check_field("reset_drive", 32'(owed.reset_drive), 32'(got.reset_drive));
    check_field("last", 32'(owed.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) check_result(res);
  end

  // Main sequence
  initial begin
    int closing_rows;
    seq_phase  = PH_IDLE;
    busy_cmd   = CMD_NONE;
    held_lba   = '0;
    held_count = '0;
    words_left = '0;
    id_index   = '0;
    total_lo   = '0;
    total_hi   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    play_rows(0, head_rows);

    // Random part: drive well-formed exchanges, with noise mixed in, until the budget is used
    closing_rows = script_reqs.size() - head_rows;
    while (items_sent + closing_rows < TOTAL_ITEMS || identify_runs == 0) begin
      steady <= (items_sent >= 150) && (items_sent < 260);
      issue(next_request(), -1);
    end
    steady <= 1'b0;

    play_rows(head_rows, script_reqs.size());
    req_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d acted on), checked %0d results.",
             items_sent, items_taken, results_seen);
    $display("Completed %0d identify runs and %0d full sector reads, ended in device-error halt.",
             identify_runs, read_runs);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("[ata_pio_host_command_sequencer_unit] OK");
    end else begin
      $display("[ata_pio_host_command_sequencer_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Timed out with %0d results still owed.", expected_results.size());
    $display("[ata_pio_host_command_sequencer_unit] ERROR");
    $finish;
  end

endmodule
